>>> src/rpn_pkg.sv
// shared types and constants for the reverse polish evaluator
package rpn_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned CNT_W       = $clog2(WORD_W);
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_DIV  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_RUN,
    ALU_FIX
  } alu_state_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_ALU,
    CTL_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

endpackage

>>> src/rpn_stack_mem.sv
// operand stack storage, one write port and one registered read port
module rpn_stack_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AddrW-1:0]                 waddr_i,
  input  logic [rpn_pkg::WORD_W-1:0]       wdata_i,
  input  logic                             re_i,
  input  logic [AddrW-1:0]                 raddr_i,
  output logic [rpn_pkg::WORD_W-1:0]       rdata_o
);
  import rpn_pkg::*;

  logic [WORD_W-1:0] mem [Depth];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rpn_alu.sv
// serial arithmetic unit: bit-serial add/sub, shift-add multiply, restoring divide
module rpn_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rpn_pkg::alu_req_t          req_i,
  input  logic [rpn_pkg::WORD_W-1:0] a_i,
  input  logic [rpn_pkg::WORD_W-1:0] b_i,
  output logic                       done_o,
  output logic [rpn_pkg::WORD_W-1:0] result_o
);
  import rpn_pkg::*;

  alu_state_e        state_q, state_d;
  alu_op_e           op_q, op_d;
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] y_q, y_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              carry_q, carry_d;
  logic              neg_q, neg_d;

  logic              sum_bit;
  logic              carry_nx;
  logic [WORD_W+1:0] trial;
  logic [WORD_W-1:0] mul_sum;
  logic [WORD_W-1:0] a_mag;
  logic [WORD_W-1:0] b_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    x_q     <= x_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    carry_q <= carry_d;
    neg_q   <= neg_d;
  end

  // one full adder for the serial add
  assign sum_bit  = x_q[0] ^ y_q[0] ^ carry_q;
  assign carry_nx = (x_q[0] & y_q[0]) | (x_q[0] & carry_q) | (y_q[0] & carry_q);
  // partial remainder shifted left with the next dividend bit, minus divisor
  assign trial    = {1'b0, acc_q, x_q[WORD_W-1]} - {2'b00, y_q};
  assign mul_sum  = acc_q + (y_q[0] ? x_q : '0);
  assign a_mag    = a_i[WORD_W-1] ? (~a_i + 1'b1) : a_i;
  assign b_mag    = b_i[WORD_W-1] ? (~b_i + 1'b1) : b_i;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    carry_d = carry_q;
    neg_d   = neg_q;
    done_o  = 1'b0;

    unique case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          op_d    = req_i.op;
          cnt_d   = '0;
          acc_d   = '0;
          carry_d = (req_i.op == ALU_SUB);
          neg_d   = a_i[WORD_W-1] ^ b_i[WORD_W-1];
          x_d     = (req_i.op == ALU_DIV) ? a_mag : a_i;
          unique case (req_i.op)
            ALU_SUB: y_d = ~b_i;
            ALU_DIV: y_d = b_mag;
            default: y_d = b_i;
          endcase
          state_d = ALU_RUN;
        end
      end
      ALU_RUN: begin
        unique case (op_q)
          ALU_ADD, ALU_SUB: begin
            acc_d   = {sum_bit, acc_q[WORD_W-1:1]};
            carry_d = carry_nx;
            x_d     = x_q >> 1;
            y_d     = y_q >> 1;
          end
          ALU_MUL: begin
            acc_d = mul_sum;
            x_d   = x_q << 1;
            y_d   = y_q >> 1;
          end
          ALU_DIV: begin
            if (!trial[WORD_W+1]) begin
              acc_d = trial[WORD_W-1:0];
              x_d   = {x_q[WORD_W-2:0], 1'b1};
            end else begin
              acc_d = {acc_q[WORD_W-2:0], x_q[WORD_W-1]};
              x_d   = {x_q[WORD_W-2:0], 1'b0};
            end
          end
          default: ;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(WORD_W - 1)) begin
          state_d = ALU_FIX;
        end
      end
      ALU_FIX: begin
        done_o  = 1'b1;
        state_d = ALU_IDLE;
      end
      default: state_d = ALU_IDLE;
    endcase
  end

  // quotient sign applied on the way out
  assign result_o = (op_q == ALU_DIV) ? (neg_q ? (~x_q + 1'b1) : x_q) : acc_q;

endmodule

>>> src/rpn_stack_evaluator.sv
// top level of the reverse polish expression evaluator
//
//  channel   dir  beats                  tdata / tuser
//  s_axis    in   one token per request  tdata[31:0] operand; tuser[2:0] mode; tlast end
//  m_axis    out  one result per expression tdata[31:0] value; tuser[1:0] status
//
// push and unused tokens are handled when accepted; an operator with two operands passes through accept,
//   one stack memory read, 32 steps of the serial alu and the alu result state
// a division by zero is caught after the stack memory read and skips the alu
// a final token passes through the emit state to load the result register
// reset empties the stack by clearing the stack count; storage itself is not cleared
// a waiting result holds in its register while the next tokens go on; a second
//   final token waits for that register to be taken
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // operand [31:0]
  input  logic [rpn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // mode [2:0]
  input  logic [rpn_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value [31:0]
  output logic [rpn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // status [1:0]
  output logic [rpn_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);
  import rpn_pkg::*;

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW  = $clog2(STACK_DEPTH);

  // keep the first error of the expression
  function automatic status_e keep_first(status_e cur, status_e code);
    keep_first = (cur == ST_OK) ? code : cur;
  endfunction

  ctl_state_e        state_q, state_d;
  logic [SPW-1:0]    sp_q, sp_d;
  status_e           sticky_q, sticky_d;
  logic              last_q, last_d;
  alu_op_e           op_q, op_d;
  logic [WORD_W-1:0] tos_q, tos_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;

  logic [SPW-1:0]    sp_m1;
  logic [SPW-1:0]    sp_m2;
  logic [MODE_W-1:0] in_mode;
  logic [WORD_W-1:0] in_operand;
  logic              in_accept;
  logic              is_arith;
  alu_op_e           arith_op;
  logic              emit_load;

  logic              mem_we;
  logic              mem_re;
  logic [WORD_W-1:0] mem_rdata;

  alu_req_t          alu_req;
  logic              alu_done;
  logic [WORD_W-1:0] alu_result;

  assign sp_m1      = sp_q - SPW'(1);
  assign sp_m2      = sp_q - SPW'(2);
  assign in_mode    = s_axis_tuser[MODE_W-1:0];
  assign in_operand = s_axis_tdata[WORD_W-1:0];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign emit_load  = (state_q == CTL_EMIT) && (!out_valid_q || m_axis_tready);

  // tos lives in a register, the memory holds the entries below it
  rpn_stack_mem #(
    .Depth (STACK_DEPTH),
    .AddrW (AW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (sp_m1[AW-1:0]),
    .wdata_i (tos_q),
    .re_i    (mem_re),
    .raddr_i (sp_m2[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // left operand comes from memory, right operand is tos
  rpn_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (mem_rdata),
    .b_i      (tos_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  // token decode
  always_comb begin
    is_arith = 1'b1;
    arith_op = ALU_ADD;
    unique case (in_mode)
      MODE_ADD: arith_op = ALU_ADD;
      MODE_SUB: arith_op = ALU_SUB;
      MODE_MUL: arith_op = ALU_MUL;
      MODE_DIV: arith_op = ALU_DIV;
      default:  is_arith = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTL_IDLE;
      sp_q        <= '0;
      sticky_q    <= ST_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      sticky_q    <= sticky_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    tos_q        <= tos_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    sticky_d      = sticky_q;
    last_d        = last_q;
    op_d          = op_q;
    tos_d         = tos_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_value_d   = out_value_q;
    out_status_d  = out_status_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    s_axis_tready = (state_q == CTL_IDLE);

    unique case (state_q)
      CTL_IDLE: begin
        if (in_accept) begin
          last_d  = s_axis_tlast;
          state_d = s_axis_tlast ? CTL_EMIT : CTL_IDLE;
          if (in_mode == MODE_PUSH) begin
            if (sp_q == SPW'(STACK_DEPTH)) begin
              sticky_d = keep_first(sticky_q, ST_OVERFLOW);
            end else begin
              // spill old tos below the new one
              mem_we = (sp_q != '0);
              tos_d  = in_operand;
              sp_d   = sp_q + SPW'(1);
            end
          end else if (is_arith) begin
            if (sp_q < SPW'(2)) begin
              sticky_d = keep_first(sticky_q, ST_UNDERFLOW);
            end else begin
              mem_re  = 1'b1;
              op_d    = arith_op;
              state_d = CTL_READ;
            end
          end
        end
      end
      CTL_READ: begin
        if (op_q == ALU_DIV && tos_q == '0) begin
          tos_d    = '0;
          sp_d     = sp_m1;
          sticky_d = keep_first(sticky_q, ST_DIVZERO);
          state_d  = last_q ? CTL_EMIT : CTL_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = CTL_ALU;
        end
      end
      CTL_ALU: begin
        if (alu_done) begin
          tos_d   = alu_result;
          sp_d    = sp_m1;
          state_d = last_q ? CTL_EMIT : CTL_IDLE;
        end
      end
      CTL_EMIT: begin
        if (emit_load) begin
          out_valid_d  = 1'b1;
          out_value_d  = (sp_q != '0) ? tos_q : '0;
          out_status_d = (sp_q == '0) ? keep_first(sticky_q, ST_UNDERFLOW) : sticky_q;
          sp_d         = '0;
          sticky_d     = ST_OK;
          state_d      = CTL_IDLE;
        end
      end
      default: state_d = CTL_IDLE;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (sp_q == '0 && sticky_q == ST_OK && m_axis_tvalid))
    else $error("expression state not cleared after result");

  a_alu_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == CTL_ALU))
    else $error("alu finished while not waited on");

endmodule
